@@ rtl/core/lpd_pkg.sv @@
// Package for the length-prefix deframer: word types, status and command codes,
// and the deframer phase encoding. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

   // Command codes carried with each request word.
   localparam logic CMD_DATA    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Status codes carried with each response word.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // Largest payload length after reset.
   localparam logic [31:0] MAX_FRAME_SIZE_RESET = 32'd65536;

   // Deframer phase, one-hot.
   typedef enum logic [2:0] {
      PH_PREFIX  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_ERROR   = 3'b100
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  payload_byte;
      logic        first_of_frame;
      logic        last_of_frame;
      logic [31:0] frame_length;
   } rsp_type;

   // Outcome of processing one request word.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } step_result_type;

endpackage

`default_nettype wire

@@ rtl/core/lpd_step.sv @@
// Deframer state and the per-word step logic of the length-prefix deframer.
// Depends on lpd_pkg for word types, codes and the phase encoding.
`timescale 1ns / 1ps
`default_nettype none

module lpd_step (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire lpd_pkg::req_type         item,
   input  wire logic [31:0]              max_frame_size,
   output lpd_pkg::step_result_type      result
);

   lpd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         prefix_count_ff, prefix_count_in;
   logic [31:0]        length_accum_ff, length_accum_in;
   logic [31:0]        bytes_remaining_ff, bytes_remaining_in;
   logic               at_first_byte_ff, at_first_byte_in;

   logic [31:0] accum_shifted;
   logic        last_byte;

   assign accum_shifted = {length_accum_ff[23:0], item.data_byte};
   assign last_byte     = (bytes_remaining_ff <= 32'd1);

   always_comb begin
      phase_in           = phase_ff;
      prefix_count_in    = prefix_count_ff;
      length_accum_in    = length_accum_ff;
      bytes_remaining_in = bytes_remaining_ff;
      at_first_byte_in   = at_first_byte_ff;
      result             = '0;

      if (item.cmd == lpd_pkg::CMD_RESTART) begin
         phase_in           = lpd_pkg::PH_PREFIX;
         prefix_count_in    = 2'd0;
         length_accum_in    = 32'd0;
         bytes_remaining_in = 32'd0;
         at_first_byte_in   = 1'b1;
      end else begin
         unique case (phase_ff)
            lpd_pkg::PH_PREFIX: begin
               length_accum_in = accum_shifted;
               if (prefix_count_ff != 2'd3) begin
                  prefix_count_in = prefix_count_ff + 2'd1;
               end else begin
                  prefix_count_in = 2'd0;
                  if (accum_shifted > max_frame_size) begin
                     phase_in                 = lpd_pkg::PH_ERROR;
                     result.valid             = 1'b1;
                     result.rsp.status        = lpd_pkg::ST_TOO_LARGE;
                     result.rsp.frame_length  = accum_shifted;
                  end else if (accum_shifted == 32'd0) begin
                     phase_in                 = lpd_pkg::PH_ERROR;
                     result.valid             = 1'b1;
                     result.rsp.status        = lpd_pkg::ST_MALFORMED;
                     result.rsp.frame_length  = accum_shifted;
                  end else begin
                     phase_in           = lpd_pkg::PH_PAYLOAD;
                     bytes_remaining_in = accum_shifted;
                     at_first_byte_in   = 1'b1;
                  end
               end
            end
            lpd_pkg::PH_PAYLOAD: begin
               result.valid              = 1'b1;
               result.rsp.status         = lpd_pkg::ST_OK;
               result.rsp.payload_byte   = item.data_byte;
               result.rsp.first_of_frame = at_first_byte_ff;
               result.rsp.last_of_frame  = last_byte;
               result.rsp.frame_length   = length_accum_ff;
               at_first_byte_in          = 1'b0;
               if (last_byte) begin
                  phase_in           = lpd_pkg::PH_PREFIX;
                  prefix_count_in    = 2'd0;
                  length_accum_in    = 32'd0;
                  bytes_remaining_in = 32'd0;
                  at_first_byte_in   = 1'b1;
               end else begin
                  bytes_remaining_in = bytes_remaining_ff - 32'd1;
               end
            end
            default: begin
               // Sticky error: data words are dropped until a restart.
            end
         endcase
      end

      if (!fire) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= lpd_pkg::PH_PREFIX;
         prefix_count_ff    <= 2'd0;
         length_accum_ff    <= 32'd0;
         bytes_remaining_ff <= 32'd0;
         at_first_byte_ff   <= 1'b1;
      end else if (fire) begin
         phase_ff           <= phase_in;
         prefix_count_ff    <= prefix_count_in;
         length_accum_ff    <= length_accum_in;
         bytes_remaining_ff <= bytes_remaining_in;
         at_first_byte_ff   <= at_first_byte_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/length_prefix_deframer.sv @@
// Top level of the length-prefix deframer: request register, response register
// and the maximum-size register around lpd_step. Depends on lpd_pkg and lpd_step.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  lpd_pkg::req_type (cmd, data_byte)
// rsp_      out        rsp_valid/rsp_stall  lpd_pkg::rsp_type (status ... frame_length)
// csr_      in         csr_wr_en            max_frame_size, 32 bits, write only
//
// A request word is taken into the request register, and then the step logic updates
// the deframer state and loads any response word into the response register. One word
// enters per cycle while the response register is not held by rsp_stall.
// Synchronous reset clears both valid flags and the deframer state and sets the
// maximum frame size to 65536. A stalled response holds in its register while the
// request register still fills; req_stall rises only when both registers are full.

module length_prefix_deframer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire lpd_pkg::req_type  req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      lpd_pkg::rsp_type  rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [31:0]       csr_wr_data
);

   logic             req_valid_ff, req_valid_in;
   lpd_pkg::req_type req_word_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lpd_pkg::rsp_type rsp_word_ff;
   logic [31:0]      max_frame_size_ff;

   logic                     req_take;
   logic                     advance;
   lpd_pkg::step_result_type step_result;

   // The buffered request word moves on whenever the response register is free
   // or is being emptied in this cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   lpd_step u_step (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .item           (req_word_ff),
      .max_frame_size (max_frame_size_ff),
      .result         (step_result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step_result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         max_frame_size_ff <= lpd_pkg::MAX_FRAME_SIZE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_frame_size_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers load only when a new word is captured.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_word_ff <= req_data;
      end
      if (advance && step_result.valid) begin
         rsp_word_ff <= step_result.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

`default_nettype wire
